[src/mi4_pkg.sv]
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared types and constants for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MINOR,
      ST_COF,
      ST_DET,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } lane_ctl_type;

endpackage

[src/mi4_div_lane.sv]
// ----------------------------------------------------------------------------
// mi4_div_lane
// Serial restoring divider lane: one quotient bit per cycle, signed result
// saturated to the entry width.
// ----------------------------------------------------------------------------
module mi4_div_lane
   import mi4_pkg::*;
#(
   parameter int ENTRY_BITS = 32,
   parameter int FRAC_BITS  = 16,
   parameter int CW         = 4 * ENTRY_BITS + 4,
   parameter int NW         = CW + 2 * FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [CW-1:0]         num,
   input  logic signed [CW+ENTRY_BITS:0] den,
   output lane_ctl_type                 ctl,
   output logic        [ENTRY_BITS-1:0] quo,
   output logic                         sat
);

   localparam int DW = CW + ENTRY_BITS + 1;
   localparam int QW = NW;
   localparam int CB = $clog2(QW + 1);

   logic [NW-1:0]  nmag_ff, nmag_in;
   logic [DW-1:0]  dmag_ff, dmag_in;
   logic [DW:0]    rem_ff, rem_in;
   logic [QW-1:0]  q_ff, q_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic           neg_ff, neg_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DW:0]    trial;
   logic [DW:0]    diff;
   logic [QW-1:0]  lim;
   logic           over;

   always_comb begin
      nmag_in = nmag_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], nmag_ff[NW-1]};
      diff    = trial - {1'b0, dmag_ff};
      if (start) begin
         nmag_in = num[CW-1] ? NW'(-{{(NW-CW){num[CW-1]}}, num}) << (2 * FRAC_BITS)
                             : NW'({{(NW-CW){1'b0}}, num}) << (2 * FRAC_BITS);
         dmag_in = den[DW-1] ? DW'(-den) : DW'(den);
         neg_in  = num[CW-1] ^ den[DW-1];
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CB'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         nmag_in = nmag_ff << 1;
         if (!diff[DW]) begin
            rem_in = diff;
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      lim  = neg_ff ? (QW'(1) << (ENTRY_BITS - 1)) : (QW'(1) << (ENTRY_BITS - 1)) - 1'b1;
      over = q_ff > lim;
      sat  = over;
      if (over)
         quo = neg_ff ? {1'b1, {(ENTRY_BITS-1){1'b0}}} : {1'b0, {(ENTRY_BITS-1){1'b1}}};
      else
         quo = neg_ff ? ENTRY_BITS'(-q_ff) : ENTRY_BITS'(q_ff);
      ctl.start = start;
      ctl.busy  = busy_ff;
      ctl.done  = done_ff;
   end

endmodule

[src/matrix_inverse_4x4.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 matrix inverse by Cramer's rule in signed fixed point.
//
// Requests carry one matrix row each (req_col0..3), top row first. Rows one
// to three are stored and give no result. The fourth row starts the solve
// on one shared multiplier of ENTRY_BITS by ENTRY_BITS+1 bits: 12 pair
// products, then 16 cofactors (three terms of three partial products each)
// and then the determinant. Four divider lanes, one per inverse column, then
// solve one inverse row at a time at one quotient bit a cycle (a singular
// matrix stops after the first row). The four result rows follow, row 0
// first, one a cycle while rsp_stall is low.
// Rows are not accepted while a solve or emission is in progress.
// A stalled result holds its payload; emission resumes when rsp_stall falls.
// Reset empties the row count and drops any solve in flight.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4
   import mi4_pkg::*;
#(
   parameter int ENTRY_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ENTRY_BITS-1:0] req_col0,
   input  logic signed [ENTRY_BITS-1:0] req_col1,
   input  logic signed [ENTRY_BITS-1:0] req_col2,
   input  logic signed [ENTRY_BITS-1:0] req_col3,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ENTRY_BITS-1:0] rsp_inv0,
   output logic signed [ENTRY_BITS-1:0] rsp_inv1,
   output logic signed [ENTRY_BITS-1:0] rsp_inv2,
   output logic signed [ENTRY_BITS-1:0] rsp_inv3,
   output logic        [1:0]            rsp_out_row,
   output logic                         rsp_last_row,
   output logic                         rsp_singular,
   output logic                         rsp_clipped
);

   localparam int EB = ENTRY_BITS;
   localparam int PW = 2 * EB + 1;
   localparam int CW = 4 * EB + 4;
   localparam int DW = CW + EB + 1;

   state_type state_ff, state_in;

   logic signed [EB-1:0] m_ff [16];
   logic signed [PW-1:0] pp_ff [12];
   logic signed [CW-1:0] cof_ff [16];
   logic signed [DW-1:0] det_ff;
   logic        [1:0]    rows_ff;
   logic        [4:0]    step_ff, step_in;
   logic        [1:0]    sub_ff, sub_in;
   logic        [1:0]    limb_ff, limb_in;
   logic signed [CW-1:0] acc_ff, acc_in;
   logic        [1:0]    orow_ff;
   logic                 sing_ff, clip_ff;
   logic signed [EB-1:0] res_ff [16];
   logic                 req_take, rsp_take;

   // shared multiplier: one entry times one limb of the other operand a cycle
   logic signed [EB-1:0] ma;
   logic signed [CW-1:0] mb;
   logic        [EB-1:0] mraw;
   logic                 mtop;
   logic signed [EB:0]   mlimb;
   logic signed [2*EB:0] mp;
   logic signed [DW-1:0] mterm;

   // pair products: index p = set*6 + pair; column pair (a,b) gives a*b' - b*a' (' = row r2)
   // column pair list for rows (r1,r2): (0,1)(0,2)(0,3)(1,2)(1,3)(2,3); two row sets:
   // set0 rows 2,3 (cofactors of rows 0,1); set1 rows 0,1 (cofactors of rows 2,3)
   function automatic logic [1:0] pa(input logic [2:0] p);
      unique case (p)
         3'd0, 3'd1, 3'd2: pa = 2'd0;
         3'd3, 3'd4:       pa = 2'd1;
         default:          pa = 2'd2;
      endcase
   endfunction
   function automatic logic [1:0] pb(input logic [2:0] p);
      unique case (p)
         3'd0:             pb = 2'd1;
         3'd1, 3'd3:       pb = 2'd2;
         default:          pb = 2'd3;
      endcase
   endfunction
   function automatic logic [2:0] pidx(input logic [1:0] a, input logic [1:0] b);
      logic [3:0] k;
      k = {a, b};
      unique case (k)
         4'h1:    pidx = 3'd0;
         4'h2:    pidx = 3'd1;
         4'h3:    pidx = 3'd2;
         4'h6:    pidx = 3'd3;
         4'h7:    pidx = 3'd4;
         default: pidx = 3'd5;
      endcase
   endfunction

   // minor step: step_ff 0..11 -> set = step/6, pair = step%6; sub 0/1 two products
   logic        mset;
   logic [2:0]  mpair;
   logic [1:0]  r1, r2, ca, cb;
   // cofactor: step_ff 0..15 = (row i, col j); sub 0..2 term k; limb 0..2
   logic [1:0]  ci, cj, ck, cc [3], rr [3];
   logic        cset;
   logic [2:0]  cpi;
   logic        cpsign;

   always_comb begin
      mset  = step_ff >= 5'd6;
      mpair = mset ? 3'(step_ff - 5'd6) : step_ff[2:0];
      r1    = mset ? 2'd0 : 2'd2;
      r2    = mset ? 2'd1 : 2'd3;
      ca    = pa(mpair);
      cb    = pb(mpair);
      ci    = step_ff[3:2];
      cj    = step_ff[1:0];
      cset  = ci[1];
      // rows of the minor excluding ci; the lone row is the one from the same half
      rr[0] = cset ? (ci == 2'd2 ? 2'd3 : 2'd2) : (ci == 2'd0 ? 2'd1 : 2'd0);
      cc[0] = (cj == 2'd0) ? 2'd1 : 2'd0;
      cc[1] = (cj <= 2'd1) ? 2'd2 : 2'd1;
      cc[2] = (cj == 2'd3) ? 2'd2 : 2'd3;
      rr[1] = 2'd0;
      rr[2] = 2'd0;
      unique case (sub_ff)
         2'd0:    ck = cc[0];
         2'd1:    ck = cc[1];
         default: ck = cc[2];
      endcase
      // the other two columns in ascending order; the middle term is subtracted
      unique case (sub_ff)
         2'd0:    begin cpi = pidx(cc[1], cc[2]); cpsign = 1'b0; end
         2'd1:    begin cpi = pidx(cc[0], cc[2]); cpsign = 1'b1; end
         default: begin cpi = pidx(cc[0], cc[1]); cpsign = 1'b0; end
      endcase
      ma   = '0;
      mb   = '0;
      mtop = 1'b1;
      unique case (state_ff)
         ST_MINOR: begin
            ma = m_ff[{r1, sub_ff[0] ? cb : ca}];
            mb = CW'(m_ff[{r2, sub_ff[0] ? ca : cb}]);
         end
         ST_COF: begin
            ma   = m_ff[{rr[0], ck}];
            mb   = CW'(pp_ff[4'(cpi) + (cset ? 4'd6 : 4'd0)]);
            mtop = limb_ff == 2'd2;
         end
         ST_DET: begin
            ma   = m_ff[{2'd0, step_ff[1:0]}];
            mb   = cof_ff[{2'd0, step_ff[1:0]}];
            mtop = limb_ff == 2'd3;
         end
         default: ;
      endcase
      mraw  = mb[limb_ff * EB +: EB];
      mlimb = mtop ? $signed({mraw[EB-1], mraw}) : $signed({1'b0, mraw});
      mp    = ma * mlimb;
      unique case (limb_ff)
         2'd0:    mterm = DW'(mp);
         2'd1:    mterm = DW'(mp) <<< EB;
         2'd2:    mterm = DW'(mp) <<< (2 * EB);
         default: mterm = DW'(mp) <<< (3 * EB);
      endcase
   end

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = state_ff != ST_LOAD;

   lane_ctl_type         lctl [4];
   logic                 ldone;
   logic [EB-1:0]        lq [4];
   logic                 lsat [4];
   logic                 any_sat;
   logic [1:0]           drow_ff, drow_in;
   logic                 dstart;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sub_in   = sub_ff;
      limb_in  = limb_ff;
      acc_in   = acc_ff;
      drow_in  = drow_ff;
      dstart   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && rows_ff == 2'd3) begin
               state_in = ST_MINOR;
               step_in  = '0;
               sub_in   = '0;
               limb_in  = '0;
            end
         end
         ST_MINOR: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff[0]) begin
               sub_in  = '0;
               step_in = step_ff + 1'b1;
               if (step_ff == 5'd11) begin
                  state_in = ST_COF;
                  step_in  = '0;
               end
            end
            acc_in = sub_ff[0] ? acc_ff : CW'(mp);
         end
         ST_COF: begin
            limb_in = limb_ff + 1'b1;
            acc_in  = (sub_ff == 2'd0 && limb_ff == 2'd0) ? '0 : acc_ff;
            acc_in  = cpsign ? acc_in - CW'(mterm) : acc_in + CW'(mterm);
            if (limb_ff == 2'd2) begin
               limb_in = '0;
               sub_in  = sub_ff + 1'b1;
               if (sub_ff == 2'd2) begin
                  sub_in  = '0;
                  step_in = step_ff + 1'b1;
                  if (step_ff == 5'd15) begin
                     state_in = ST_DET;
                     step_in  = '0;
                  end
               end
            end
         end
         ST_DET: begin
            limb_in = limb_ff + 1'b1;
            if (limb_ff == 2'd3) begin
               step_in = step_ff + 1'b1;
               if (step_ff == 5'd3) begin
                  state_in = ST_DIV;
                  drow_in  = '0;
                  dstart   = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (ldone) begin
               drow_in = drow_ff + 1'b1;
               if (drow_ff == 2'd3 || sing_ff) begin
                  state_in = ST_EMIT;
                  step_in  = '0;
               end else begin
                  dstart = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_take && orow_ff == 2'd3) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   logic signed [DW-1:0] det_sum;
   assign det_sum = ((step_ff == 5'd0 && limb_ff == 2'd0) ? '0 : det_ff) + mterm;
   assign any_sat = lsat[0] || lsat[1] || lsat[2] || lsat[3];

   always_ff @(posedge clock) begin
      if (req_take) begin
         m_ff[{rows_ff, 2'd0}] <= req_col0;
         m_ff[{rows_ff, 2'd1}] <= req_col1;
         m_ff[{rows_ff, 2'd2}] <= req_col2;
         m_ff[{rows_ff, 2'd3}] <= req_col3;
      end
      if (state_ff == ST_MINOR && sub_ff[0])
         pp_ff[4'(mpair) + (mset ? 4'd6 : 4'd0)] <= PW'(acc_ff - CW'(mp));
      if (state_ff == ST_COF && sub_ff == 2'd2 && limb_ff == 2'd2)
         cof_ff[step_ff[3:0]] <= ((ci[0] ^ cj[0]) ? -acc_in : acc_in);
      if (state_ff == ST_DET) det_ff <= det_sum;
      if (ST_DET == state_ff && step_ff == 5'd3 && limb_ff == 2'd3) begin
         sing_ff <= det_sum == '0;
         clip_ff <= 1'b0;
      end
      if (state_ff == ST_DIV && ldone) begin
         for (int c = 0; c < 4; c++) begin
            res_ff[{drow_ff, 2'(c)}] <= sing_ff ? '0 : lq[c];
         end
         if (any_sat && !sing_ff) clip_ff <= 1'b1;
      end
      acc_ff  <= acc_in;
      sub_ff  <= sub_in;
      limb_ff <= limb_in;
      step_ff <= step_in;
      drow_ff <= drow_in;
      if (reset) begin
         state_ff <= ST_LOAD;
         rows_ff  <= '0;
         orow_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (req_take) rows_ff <= rows_ff + 1'b1;
         if (state_ff == ST_DIV) orow_ff <= '0;
         else if (rsp_take) orow_ff <= orow_ff + 1'b1;
      end
   end

   // lane c computes inverse(drow, c) = cof(c, drow) / det
   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_lane
         mi4_div_lane #(
            .ENTRY_BITS(ENTRY_BITS),
            .FRAC_BITS (FRAC_BITS),
            .CW        (CW)
         ) u_lane (
            .clock(clock),
            .reset(reset),
            .start(dstart),
            .num  (cof_ff[{2'(g), state_ff == ST_DET ? 2'd0 : drow_in}]),
            .den  (state_ff == ST_DET ? det_sum : det_ff),
            .ctl  (lctl[g]),
            .quo  (lq[g]),
            .sat  (lsat[g])
         );
      end
   endgenerate

   assign ldone = lctl[0].done;

   assign rsp_valid    = state_ff == ST_EMIT;
   assign rsp_inv0     = sing_ff ? '0 : res_ff[{orow_ff, 2'd0}];
   assign rsp_inv1     = sing_ff ? '0 : res_ff[{orow_ff, 2'd1}];
   assign rsp_inv2     = sing_ff ? '0 : res_ff[{orow_ff, 2'd2}];
   assign rsp_inv3     = sing_ff ? '0 : res_ff[{orow_ff, 2'd3}];
   assign rsp_out_row  = orow_ff;
   assign rsp_last_row = orow_ff == 2'd3;
   assign rsp_singular = sing_ff;
   assign rsp_clipped  = clip_ff;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 fixed-point matrix inverse.
//
// Matrices are sent as four row requests. Each accepted row goes into a local
// row store; on the fourth row the bench forms the exact inverse in wide
// integers, rounded toward zero and saturated to the entry width, and queues
// the four expected result rows. A checker compares every accepted result
// row field by field with the oldest expected row. Directed tests cover the
// identity, negation, singular matrices, saturation and the extreme entry
// values. Random matrices then run under several sender and receiver idling
// phases.
// ----------------------------------------------------------------------------
module tb_top;
   import mi4_pkg::*;

   localparam int ENTRY_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int WATCHDOG_MAX = 40000;
   localparam int DRAIN_CYCLES = 400;

   typedef logic signed [ENTRY_BITS-1:0] entry_type;
   typedef entry_type                    matrix_type [4][4];
   typedef logic signed [255:0]          wide_type;

   typedef struct {
      entry_type  inv [4];
      logic [1:0] out_row;
      logic       last_row;
      logic       singular;
      logic       clipped;
   } inv_row_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   entry_type req_col0, req_col1, req_col2, req_col3;
   logic      rsp_valid;
   logic      rsp_stall;
   entry_type rsp_inv0, rsp_inv1, rsp_inv2, rsp_inv3;
   logic [1:0] rsp_out_row;
   logic      rsp_last_row;
   logic      rsp_singular;
   logic      rsp_clipped;

   inv_row_type expected_rows [$];
   entry_type   loaded_rows [4][4];
   int          rows_loaded;
   int          error_count = 0;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles = 0;

   matrix_inverse_4x4 #(
      .ENTRY_BITS (ENTRY_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_col0     (req_col0),
      .req_col1     (req_col1),
      .req_col2     (req_col2),
      .req_col3     (req_col3),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_inv0     (rsp_inv0),
      .rsp_inv1     (rsp_inv1),
      .rsp_inv2     (rsp_inv2),
      .rsp_inv3     (rsp_inv3),
      .rsp_out_row  (rsp_out_row),
      .rsp_last_row (rsp_last_row),
      .rsp_singular (rsp_singular),
      .rsp_clipped  (rsp_clipped)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // 3x3 determinant of the matrix left after dropping one row and one column
   function automatic wide_type minor3(int skip_r, int skip_c);
      int       r [3];
      int       c [3];
      int       nr;
      int       nc;
      wide_type acc;
      nr  = 0;
      nc  = 0;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         if (k != skip_r) begin
            r[nr] = k;
            nr++;
         end
         if (k != skip_c) begin
            c[nc] = k;
            nc++;
         end
      end
      for (int k = 0; k < 3; k++) begin
         acc += wide_type'(loaded_rows[r[0]][c[k]])
              * (wide_type'(loaded_rows[r[1]][c[(k+1)%3]])
                 * wide_type'(loaded_rows[r[2]][c[(k+2)%3]])
               - wide_type'(loaded_rows[r[1]][c[(k+2)%3]])
                 * wide_type'(loaded_rows[r[2]][c[(k+1)%3]]));
      end
      return acc;
   endfunction

   task automatic solve_inverse();
      wide_type    cof [4][4];
      wide_type    det;
      wide_type    num;
      wide_type    den;
      wide_type    quo;
      wide_type    lim;
      logic        neg;
      logic        singular;
      logic        clipped;
      entry_type   res [4][4];
      inv_row_type row;
      det     = '0;
      clipped = 1'b0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            cof[i][j] = minor3(i, j);
            if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
         end
      for (int j = 0; j < 4; j++) det += cof[0][j] * wide_type'(loaded_rows[0][j]);
      singular = (det == 0);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            res[i][j] = '0;
            if (!singular) begin
               num = cof[j][i] <<< (2 * FRAC_BITS);
               den = det;
               neg = num[255] ^ den[255];
               if (num[255]) num = -num;
               if (den[255]) den = -den;
               quo = wide_type'($unsigned(num) / $unsigned(den));
               lim = neg ? (wide_type'(1) <<< (ENTRY_BITS - 1))
                         : (wide_type'(1) <<< (ENTRY_BITS - 1)) - 1;
               if (quo > lim) begin
                  quo     = lim;
                  clipped = 1'b1;
               end
               res[i][j] = neg ? entry_type'(-quo) : entry_type'(quo);
            end
         end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) row.inv[j] = res[i][j];
         row.out_row  = 2'(i);
         row.last_row = (i == 3);
         row.singular = singular;
         row.clipped  = clipped;
         expected_rows.push_back(row);
      end
   endtask

   task automatic send_row(entry_type c0, entry_type c1, entry_type c2, entry_type c3);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_col0  = c0;
      req_col1  = c1;
      req_col2  = c2;
      req_col3  = c3;
      do @(posedge clock); while (req_stall);
      loaded_rows[rows_loaded] = '{c0, c1, c2, c3};
      if (rows_loaded == 3) begin
         rows_loaded = 0;
         solve_inverse();
      end else begin
         rows_loaded++;
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_matrix(matrix_type m);
      for (int r = 0; r < 4; r++) send_row(m[r][0], m[r][1], m[r][2], m[r][3]);
   endtask

   task automatic wait_drained();
      while (expected_rows.size() != 0) @(negedge clock);
   endtask

   function automatic matrix_type scaled_identity(entry_type d);
      matrix_type m;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? d : '0;
      return m;
   endfunction

   function automatic matrix_type random_full();
      matrix_type m;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) m[r][c] = $urandom;
      return m;
   endfunction

   // large diagonal entries, small off-diagonal entries
   function automatic matrix_type random_tame();
      matrix_type m;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            if (r == c) begin
               m[r][c] = $urandom_range(32'h0008_0000, 32'h0002_0000);
               if ($urandom_range(1)) m[r][c] = -m[r][c];
            end else begin
               m[r][c] = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            end
         end
      return m;
   endfunction

   function automatic matrix_type random_singular();
      matrix_type m;
      int         src;
      int         dst;
      m   = random_tame();
      src = $urandom_range(3);
      dst = (src + $urandom_range(3, 1)) % 4;
      if ($urandom_range(1)) m[dst] = m[src];
      else for (int r = 0; r < 4; r++) m[r][dst] = '0;
      return m;
   endfunction

   function automatic matrix_type random_tiny();
      matrix_type m;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            m[r][c] = $signed($urandom_range(64)) - 32;
      for (int r = 0; r < 4; r++) m[r][r] = m[r][r] + 200;
      return m;
   endfunction

   task automatic test_identity();
      send_matrix(scaled_identity(32'sh0001_0000));
      send_matrix(scaled_identity(-32'sh0001_0000));
      send_matrix(scaled_identity(32'sh0002_0000));
      wait_drained();
   endtask

   task automatic test_singular();
      send_matrix(scaled_identity('0));
      send_matrix(random_singular());
      wait_drained();
   endtask

   task automatic test_clipping();
      send_matrix(scaled_identity(32'sh0000_0001));
      send_matrix(scaled_identity(-32'sh0000_0001));
      send_matrix(random_tiny());
      wait_drained();
   endtask

   task automatic test_extremes();
      matrix_type m;
      m = scaled_identity(32'sh7fff_ffff);
      send_matrix(m);
      m = scaled_identity(32'sh8000_0000);
      send_matrix(m);
      m = scaled_identity(32'sh0001_0000);
      m[0][3] = 32'sh7fff_ffff;
      m[3][0] = 32'sh8000_0000;
      m[1][2] = -32'sh0000_0001;
      m[2][1] = 32'shffff_0000;
      send_matrix(m);
      wait_drained();
   endtask

   task automatic test_random(int matrices, int idle, int stall);
      int pick;
      idle_pct  = idle;
      stall_pct = stall;
      for (int n = 0; n < matrices; n++) begin
         pick = $urandom_range(9);
         if (pick < 5)       send_matrix(random_tame());
         else if (pick < 7)  send_matrix(random_full());
         else if (pick < 8)  send_matrix(random_singular());
         else                send_matrix(random_tiny());
      end
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (reset) rsp_stall = 1'b0;
      else rsp_stall = ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      inv_row_type want;
      entry_type   got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_inv0, rsp_inv1, rsp_inv2, rsp_inv3};
         if (expected_rows.size() == 0) begin
            $display("%0t unexpected result row %0d", $time, rsp_out_row);
            error_count++;
         end else begin
            want = expected_rows.pop_front();
            for (int j = 0; j < 4; j++)
               if (got[j] !== want.inv[j]) begin
                  $display("%0t row %0d inv%0d: expected %h actual %h",
                           $time, want.out_row, j, want.inv[j], got[j]);
                  error_count++;
               end
            if (rsp_out_row !== want.out_row) begin
               $display("%0t out_row: expected %0d actual %0d",
                        $time, want.out_row, rsp_out_row);
               error_count++;
            end
            if (rsp_last_row !== want.last_row) begin
               $display("%0t last_row: expected %b actual %b",
                        $time, want.last_row, rsp_last_row);
               error_count++;
            end
            if (rsp_singular !== want.singular) begin
               $display("%0t singular: expected %b actual %b",
                        $time, want.singular, rsp_singular);
               error_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $display("%0t clipped: expected %b actual %b",
                        $time, want.clipped, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_col0     = '0;
      req_col1     = '0;
      req_col2     = '0;
      req_col3     = '0;
      rows_loaded  = 0;
      idle_pct     = 0;
      stall_pct    = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_identity();
      test_singular();
      test_clipping();
      test_extremes();
      test_random(12, 0, 0);
      test_random(14, 76, 0);
      test_random(14, 0, 76);
      test_random(8, 10, 10);
      test_random(6, 0, 0);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_rows.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
